// File: hdl/mse_pkg.sv
// Shared types and constants of the MIPS subset execute unit.
package mse_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_IDX_W = 5;
  localparam logic [REG_IDX_W-1:0] SP_REG = 5'd29;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_ADDI   = 4'd4,
    OP_SUBI   = 4'd5,
    OP_BEQ    = 4'd6,
    OP_J      = 4'd7,
    OP_LW     = 4'd8,
    OP_SW     = 4'd9,
    OP_PRESET = 4'd10
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_MEM,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_WRITE,
    MEM_READ
  } mem_cmd_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALU,
    RES_DIV,
    RES_ADDR_ERR,
    RES_STORE,
    RES_LOAD
  } res_sel_t;

  // Input item payload, source_index in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [9:0]  jump_target;
    logic [31:0] immediate;
    logic [4:0]  dest_index;
    logic [4:0]  second_index;
    logic [4:0]  source_index;
  } in_t;

  // Result item payload, reg_written in the lowest bits.
  typedef struct packed {
    logic        address_error;
    logic        divide_by_zero;
    logic [9:0]  next_index;
    logic        jump_taken;
    logic        branch_taken;
    logic [9:0]  mem_address;
    logic        mem_written;
    logic [31:0] written_value;
    logic [4:0]  written_index;
    logic        reg_written;
  } out_t;

  typedef struct packed {
    logic     capture;
    logic     rf_read;
    logic     exec;
    logic     div_start;
    mem_cmd_t mem_op;
    res_sel_t res_sel;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic is_mem;
    logic is_load;
    logic addr_ok;
    logic div_done;
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/mse_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module mse_div import mse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_shift;
  logic [33:0] diff;

  assign rem_shift = {rem, quo[31]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs};
  assign quotient  = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem <= '0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      // restoring step: keep the difference when it did not borrow
      if (!diff[33]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_shift[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/mse_dpath.sv
// Datapath: instruction capture, register file, data memory, ALU, divider, result register.
module mse_dpath import mse_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  input  cmd_t        cmd,
  output stat_t       stat
);

  localparam int AW = $clog2(MEM_WORDS);

  in_t               in_word;
  op_t               op;
  logic [4:0]        rs;
  logic [4:0]        rt;
  logic [4:0]        rd;
  logic [31:0]       imm;
  logic [9:0]        target;

  logic [31:0]       rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [31:0]       rdata_a;
  logic [31:0]       rdata_b;
  logic              vld_a;
  logic              vld_b;
  logic [31:0]       opa;
  logic [31:0]       opb;

  logic [31:0]       mem [MEM_WORDS];
  logic [31:0]       mem_rdata;
  logic [AW-1:0]     clr_cnt;
  logic [33:0]       addr;
  logic              round_up;

  logic              div_done;
  logic [31:0]       div_quo;

  out_t              alu_res;
  out_t              div_res;
  out_t              err_res;
  out_t              store_res;
  out_t              load_res;
  out_t              res;
  out_t              out_item;
  logic              out_valid;

  assign in_word = in_t'(s_tdata);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= op_t'(s_tuser);
      rs     <= in_word.source_index;
      rt     <= in_word.second_index;
      rd     <= in_word.dest_index;
      imm    <= in_word.immediate;
      target <= in_word.jump_target;
    end
  end

  // Register file: two registered read ports, one write port at commit.
  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      rdata_a <= rf[rs];
      rdata_b <= rf[rt];
    end
    if (cmd.commit && res.reg_written) begin
      rf[res.written_index] <= res.written_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      vld_a  <= 1'b0;
      vld_b  <= 1'b0;
    end else begin
      if (cmd.rf_read) begin
        vld_a <= rf_vld[rs];
        vld_b <= rf_vld[rt];
      end
      if (cmd.commit && res.reg_written) begin
        rf_vld[res.written_index] <= 1'b1;
      end
    end
  end

  assign opa = vld_a ? rdata_a : '0;
  assign opb = vld_b ? rdata_b : '0;

  // Data memory: one port, shared by the clearing sweep, stores and loads.
  always_ff @(posedge clk) begin
    unique case (cmd.mem_op)
      MEM_CLEAR: mem[clr_cnt] <= '0;
      MEM_WRITE: mem[addr[AW-1:0]] <= opb;
      MEM_READ:  mem_rdata <= mem[addr[AW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_op == MEM_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Word address: base / 4 toward zero plus offset, as one add with carry-in.
  assign round_up = opa[31] & (opa[1:0] != 2'b00);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      addr <= {{4{opa[31]}}, opa[31:2]} + {{2{imm[31]}}, imm} + 34'(round_up);
    end
  end

  mse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    alu_res = '0;
    unique case (op)
      OP_ADD: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rd;
        alu_res.written_value = opa + opb;
      end
      OP_SUB: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rd;
        alu_res.written_value = opa - opb;
      end
      OP_MUL: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rd;
        alu_res.written_value = opa * opb;
      end
      OP_ADDI: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rt;
        alu_res.written_value = opa + imm;
      end
      OP_SUBI: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rt;
        alu_res.written_value = opa - imm;
      end
      OP_BEQ: alu_res.branch_taken = (opa == opb);
      OP_J: begin
        alu_res.jump_taken = 1'b1;
        alu_res.next_index = target;
      end
      OP_PRESET: begin
        alu_res.reg_written   = 1'b1;
        alu_res.written_index = rd;
        alu_res.written_value = imm;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_res                = '0;
    div_res.reg_written    = 1'b1;
    div_res.written_index  = rd;
    div_res.divide_by_zero = (opb == 32'd0);
    div_res.written_value  = (opb == 32'd0) ? 32'd0 : div_quo;

    err_res               = '0;
    err_res.address_error = 1'b1;

    store_res               = '0;
    store_res.mem_written   = 1'b1;
    store_res.mem_address   = addr[9:0];
    store_res.written_value = opb;

    load_res               = '0;
    load_res.reg_written   = 1'b1;
    load_res.written_index = rt;
    load_res.written_value = mem_rdata;
    load_res.mem_address   = addr[9:0];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_ALU:      res <= alu_res;
      RES_DIV:      res <= div_res;
      RES_ADDR_ERR: res <= err_res;
      RES_STORE:    res <= store_res;
      RES_LOAD:     res <= load_res;
      default: ;
    endcase
  end

  // Output register: load on commit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_item};

  assign stat.is_div     = (op == OP_DIV);
  assign stat.is_mem     = ((op == OP_LW) || (op == OP_SW)) && (rs == SP_REG);
  assign stat.is_load    = (op == OP_LW);
  assign stat.addr_ok    = !addr[33] && (addr[32:0] < 33'(MEM_WORDS));
  assign stat.div_done   = div_done;
  assign stat.clear_last = (clr_cnt == AW'(MEM_WORDS - 1));
  assign stat.out_free   = !out_valid || m_tready;

endmodule

// File: hdl/mse_ctrl.sv
// Controller state machine that sequences one instruction at a time.
module mse_ctrl import mse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.mem_op  = MEM_IDLE;
    cmd.res_sel = RES_NONE;
    unique case (state)
      ST_CLEAR: begin
        cmd.mem_op = MEM_CLEAR;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rf_read = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (stat.is_mem) begin
          state_next = ST_MEM;
        end else begin
          cmd.res_sel = RES_ALU;
          state_next  = ST_DONE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.res_sel = RES_DIV;
          state_next  = ST_DONE;
        end
      end
      ST_MEM: begin
        if (!stat.addr_ok) begin
          cmd.res_sel = RES_ADDR_ERR;
          state_next  = ST_DONE;
        end else if (stat.is_load) begin
          cmd.mem_op = MEM_READ;
          state_next = ST_LOAD;
        end else begin
          cmd.mem_op  = MEM_WRITE;
          cmd.res_sel = RES_STORE;
          state_next  = ST_DONE;
        end
      end
      ST_LOAD: begin
        cmd.res_sel = RES_LOAD;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit.
//
// Executes one decoded instruction per input item against a 32 x 32-bit
// register file and a MEM_WORDS-deep word memory, and returns exactly one
// result item per instruction. After reset the unit sweeps the data
// memory to zero, one word per cycle, with s_tready low; the register file
// is cleared at once through per-register valid bits.
// Items are then taken one at a time: an instruction is accepted, its two
// source registers are read, it executes, and its result is loaded into
// the output register, where it waits while the next item is already
// accepted. Add, sub, mul, addi, subi, beq, j, preset and a lw/sw whose
// base is not register 29 go from execute straight to the result; an
// in-range sw first passes the memory state, lw the memory and load states;
// div waits on the 32-step shift-and-subtract divider producing one
// quotient bit per cycle. A result that is not taken holds the unit only
// once the next result is ready to leave.
module mips_subset_execute_unit import mse_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: source_index[4:0], second_index[9:5], dest_index[14:10],
  //          immediate[46:15], jump_target[56:47], zero pad [63:57]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,  // opcode[3:0]
  // m_tdata: reg_written[0], written_index[5:1], written_value[37:6],
  //          mem_written[38], mem_address[48:39], branch_taken[49],
  //          jump_taken[50], next_index[60:51], divide_by_zero[61],
  //          address_error[62], zero pad [63]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each item: clear sweep, accept, read, execute, wait, commit.
  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the architectural state and the result register.
  mse_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
